// ===== design/sbr_pkg.sv =====
// Package for the SBUS frame receiver: frame layout constants, the shared frame type
// and the end-byte check. No dependencies.
package sbr_pkg;

  localparam int unsigned FrameLen   = 26;
  localparam int unsigned NumChans   = 16;
  localparam int unsigned ChanBits   = 11;
  localparam int unsigned DataBytes  = 22;
  localparam int unsigned DataBits   = DataBytes * 8;
  localparam int unsigned QDepthDflt = 2;
  localparam int unsigned PosBits    = 5;
  localparam int unsigned ChBits     = 4;

  localparam logic [PosBits-1:0] PosHunt  = 5'd0;
  localparam logic [PosBits-1:0] PosData1 = 5'd1;
  localparam logic [PosBits-1:0] PosDataN = 5'd22;
  localparam logic [PosBits-1:0] PosFlags = 5'd23;
  localparam logic [PosBits-1:0] PosEnd   = 5'd24;
  localparam logic [PosBits-1:0] PosNext  = 5'd25;

  localparam logic [7:0] StartByte = 8'h0F;
  localparam logic [7:0] EndCode0  = 8'h00;
  localparam logic [7:0] EndCode1  = 8'h04;
  localparam logic [7:0] EndCode2  = 8'h14;
  localparam logic [7:0] EndCode3  = 8'h24;
  localparam logic [7:0] EndCode4  = 8'h34;
  localparam logic [7:0] FlagFs    = 8'h08;
  localparam logic [7:0] FlagLost  = 8'h04;

  localparam logic [ChBits-1:0] LastChan = 4'd15;

  typedef struct packed {
    logic [DataBits-1:0] chans;
    logic                failsafe;
  } frame_t;

  function automatic logic end_ok(input logic [7:0] b);
    end_ok = (b == EndCode0) || (b == EndCode1) || (b == EndCode2) ||
             (b == EndCode3) || (b == EndCode4);
  endfunction

endpackage

// ===== design/sbus_frame_receiver.sv =====
// Channel | Direction | Handshake                 | Payload
// rx      | in        | rx_valid_i / rx_stall_o   | rx_byte_i
// out     | out       | out_valid_o / out_stall_i | channel_index_o, channel_value_o,
//         |           |                           | failsafe_o, last_channel_o
// One byte is taken per cycle unless the input stalls; the back end loads a queued frame,
// then emits its 16 items, one per cycle while the output is not stalled.
// The input stalls only at the 26th byte of a frame while the frame queue is full.
// Reset clears the frame position (hunting), the queue, the back end state and the output valid flag.
// Output stalls hold the current item and pause the unpack shifter.
// Top level of the SBUS frame receiver; depends on sbr_pkg, sbr_front,
// sbr_queue and sbr_back.
module sbus_frame_receiver
  import sbr_pkg::*;
#(
  parameter int unsigned QueueDepth = QDepthDflt
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rx_valid_i,
  output logic                rx_stall_o,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ChBits-1:0]   channel_index_o,
  output logic [ChanBits-1:0] channel_value_o,
  output logic                failsafe_o,
  output logic                last_channel_o
);

  logic   q_full, q_push, q_empty, q_pop;
  frame_t wr_frame, rd_frame;

  sbr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_frame_o  (wr_frame)
  );

  sbr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .frame_i (wr_frame),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .frame_o (rd_frame)
  );

  sbr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_frame_i       (rd_frame),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .failsafe_o      (failsafe_o),
    .last_channel_o  (last_channel_o)
  );

endmodule

// ===== design/sbr_front.sv =====
// Front end: hunts for the start byte, collects one frame and checks it.
// Depends on sbr_pkg.
module sbr_front
  import sbr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output frame_t     q_frame_o
);

  logic [PosBits-1:0]  pos_q, pos_d;
  logic [DataBits-1:0] data_q;
  logic                fs_q;
  logic                end_ok_q;
  logic                accept;

  assign rx_stall_o = (pos_q == PosNext) && q_full_i;
  assign accept     = rx_valid_i && !rx_stall_o;

  always_comb begin
    pos_d    = pos_q;
    q_push_o = 1'b0;
    if (accept) begin
      if (pos_q == PosHunt) begin
        if (rx_byte_i == StartByte) pos_d = PosData1;
      end else if (pos_q == PosNext) begin
        if (end_ok_q && (rx_byte_i == StartByte)) begin
          q_push_o = 1'b1;
          pos_d    = PosData1;
        end else begin
          pos_d = PosHunt;
        end
      end else begin
        pos_d = pos_q + PosData1;
      end
    end
  end

  assign q_frame_o.chans    = data_q;
  assign q_frame_o.failsafe = fs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosHunt;
    end else begin
      pos_q <= pos_d;
    end
  end

  // shift data bytes in from the top so byte 1 ends up least significant
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if ((pos_q >= PosData1) && (pos_q <= PosDataN)) begin
        data_q <= {rx_byte_i, data_q[DataBits-1:8]};
      end
      if (pos_q == PosFlags) begin
        fs_q <= |(rx_byte_i & (FlagFs | FlagLost));
      end
      if (pos_q == PosEnd) begin
        end_ok_q <= end_ok(rx_byte_i);
      end
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosNext)
    else $error("frame position out of range");
  a_push_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |=> (pos_q == PosData1))
    else $error("push did not restart frame at byte 1");
`endif

endmodule

// ===== design/sbr_queue.sv =====
// Short frame queue between front and back end.
// Depends on sbr_pkg.
module sbr_queue
  import sbr_pkg::*;
#(
  parameter int unsigned Depth = QDepthDflt
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t frame_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output frame_t frame_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);
  localparam logic [PtrBits-1:0] PtrLast = PtrBits'(Depth - 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(Depth);

  frame_t             mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign frame_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrBits'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrBits'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntBits'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= frame_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");
`endif

endmodule

// ===== design/sbr_back.sv =====
// Back end: unpacks one queued frame into 16 channel items, one per cycle unless the output stalls.
// Depends on sbr_pkg.
module sbr_back
  import sbr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  frame_t              q_frame_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ChBits-1:0]   channel_index_o,
  output logic [ChanBits-1:0] channel_value_o,
  output logic                failsafe_o,
  output logic                last_channel_o
);

  logic                busy_q, busy_d;
  logic [ChBits-1:0]   ch_q, ch_d;
  logic                out_valid_q, out_valid_d;
  logic [DataBits-1:0] chans_q;
  logic                fs_q;
  logic                adv;
  logic                emit;

  assign adv     = !out_valid_q || !out_stall_i;
  assign q_pop_o = !busy_q && !q_empty_i;
  assign emit    = busy_q && adv;

  always_comb begin
    busy_d      = busy_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q;
    if (q_pop_o) begin
      busy_d = 1'b1;
      ch_d   = '0;
    end else if (emit) begin
      ch_d   = ch_q + ChBits'(1);
      busy_d = (ch_q != LastChan);
    end
    if (adv) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      chans_q <= q_frame_i.chans;
      fs_q    <= q_frame_i.failsafe;
    end else if (emit) begin
      chans_q <= chans_q >> ChanBits;
    end
    if (emit) begin
      channel_index_o <= ch_q;
      channel_value_o <= chans_q[ChanBits-1:0];
      failsafe_o      <= fs_q;
      last_channel_o  <= (ch_q == LastChan);
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_chan_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !last_channel_o) |=>
      (out_valid_q && (channel_index_o == ChBits'($past(channel_index_o) + 1'b1))))
    else $error("channel items not consecutive");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (busy_q && (ch_q == '0)))
    else $error("frame load did not start at channel 0");
`endif

endmodule

// ===== test/tb_sbus_frame_receiver.sv =====
// Testbench for sbus_frame_receiver: byte stream in, channel items out.
// A scoreboard class decodes frames on its own and checks every item in order.
// Depends on sbr_pkg and the sbus_frame_receiver RTL.
`timescale 1ns / 1ps

module tb_sbus_frame_receiver;
  import sbr_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomBytes   = 140;
  localparam int unsigned TailCycles    = 40;
  localparam logic [7:0] EndCodes [5] = '{EndCode0, EndCode1, EndCode2, EndCode3, EndCode4};

  typedef struct {
    logic [ChBits-1:0]   idx;
    logic [ChanBits-1:0] val;
    logic                fs;
    logic                last;
  } chan_item_t;

  class frame_scoreboard;
    chan_item_t  chans_due_q[$];
    logic [7:0]  frame_q [FrameLen];
    int unsigned pos;
    int unsigned errors;
    int unsigned items_seen;
    int unsigned bytes_taken;
    int unsigned frames_good;
    int unsigned frames_fs;

    function new();
      pos = 0;
      errors = 0;
      items_seen = 0;
      bytes_taken = 0;
      frames_good = 0;
      frames_fs = 0;
    endfunction

    function void mismatch(string msg);
      errors++;
      if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function void note_byte(logic [7:0] b);
      logic [DataBits-1:0] chans;
      logic                fs;
      chan_item_t          it;
      bytes_taken++;
      if (pos >= FrameLen) pos = 0;
      if (pos == 0 && b != StartByte) return;
      frame_q[pos] = b;
      pos++;
      if (pos < FrameLen) return;
      if (!(frame_q[PosEnd] inside {EndCode0, EndCode1, EndCode2, EndCode3, EndCode4}) ||
          frame_q[PosNext] != StartByte) begin
        pos = 0;
        return;
      end
      for (int i = 0; i < DataBytes; i++) chans[8*i +: 8] = frame_q[PosData1 + i];
      fs = |(frame_q[PosFlags] & (FlagFs | FlagLost));
      for (int ch = 0; ch < NumChans; ch++) begin
        it.idx  = ch[ChBits-1:0];
        it.val  = chans[ChanBits*ch +: ChanBits];
        it.fs   = fs;
        it.last = (ch[ChBits-1:0] == LastChan);
        chans_due_q.push_back(it);
      end
      frames_good++;
      if (fs) frames_fs++;
      frame_q[PosHunt] = frame_q[PosNext];
      pos = 1;
    endfunction

    function void check_item(logic [ChBits-1:0] idx, logic [ChanBits-1:0] val,
                             logic fs, logic last);
      chan_item_t exp_it;
      items_seen++;
      if (chans_due_q.size() == 0) begin
        mismatch($sformatf("unexpected item idx=%0d val=%0d fs=%0b last=%0b",
                           idx, val, fs, last));
        return;
      end
      exp_it = chans_due_q.pop_front();
      if (idx !== exp_it.idx)
        mismatch($sformatf("channel_index exp %0d got %0d", exp_it.idx, idx));
      if (val !== exp_it.val)
        mismatch($sformatf("channel_value ch%0d exp %0d got %0d", exp_it.idx, exp_it.val, val));
      if (fs !== exp_it.fs)
        mismatch($sformatf("failsafe ch%0d exp %0b got %0b", exp_it.idx, exp_it.fs, fs));
      if (last !== exp_it.last)
        mismatch($sformatf("last_channel ch%0d exp %0b got %0b", exp_it.idx, exp_it.last, last));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                rx_valid_i = 1'b0;
  logic                rx_stall_o;
  logic [7:0]          rx_byte_i = 8'h00;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ChBits-1:0]   channel_index_o;
  logic [ChanBits-1:0] channel_value_o;
  logic                failsafe_o;
  logic                last_channel_o;

  logic            burst = 1'b0;
  int unsigned     idle_cycles;
  int unsigned     directed_bytes;
  frame_scoreboard sb = new();

  sbus_frame_receiver u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_valid_i     (rx_valid_i),
    .rx_stall_o     (rx_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .channel_index_o(channel_index_o),
    .channel_value_o(channel_value_o),
    .failsafe_o     (failsafe_o),
    .last_channel_o (last_channel_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(negedge clk_i);
    while (rx_stall_o) @(negedge clk_i);
    sb.note_byte(b);
    @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [DataBits-1:0] chans, input logic [7:0] flags,
                            input logic [7:0] end_b);
    send_byte(StartByte);
    for (int i = 0; i < DataBytes; i++) send_byte(chans[8*i +: 8]);
    send_byte(flags);
    send_byte(end_b);
  endtask

  function automatic logic [DataBits-1:0] rand_chans();
    logic [DataBits-1:0] v;
    for (int i = 0; i < DataBytes; i++) v[8*i +: 8] = 8'($urandom_range(0, 255));
    return v;
  endfunction

  // drain side: random stall before each item
  initial begin
    int k;
    @(posedge rst_ni);
    forever begin
      k = burst ? 0 : $urandom_range(0, 6);
      if (k > 0) begin
        out_stall_i <= 1'b1;
        repeat (k) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(negedge clk_i);
      while (!out_valid_o) @(negedge clk_i);
      @(posedge clk_i);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_item(channel_index_o, channel_value_o, failsafe_o, last_channel_o);
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(negedge clk_i);
      if ((rx_valid_i && !rx_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("sbus_frame_receiver verification failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hunting, extremes, every end code and flag combination
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hF0);
    send_frame('1, 8'h00, EndCode0);
    send_frame('0, FlagFs, EndCode1);
    send_frame({(DataBits/4){4'h5}}, FlagLost, EndCode2);
    send_frame({(DataBits/4){4'hA}}, FlagFs | FlagLost, EndCode3);
    send_frame(rand_chans(), 8'hF3, EndCode4);
    send_byte(StartByte);
    // bad end byte: drop frame, resync
    send_frame(rand_chans(), 8'h00, 8'h05);
    send_byte(StartByte);
    send_byte(8'h11);
    // bad start of next frame
    send_frame(rand_chans(), FlagFs, EndCode0);
    send_byte(8'h8F);
    directed_bytes = sb.bytes_taken;

    while (sb.bytes_taken < directed_bytes + RandomBytes) begin
      burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 30))
            send_byte(($urandom_range(0, 3) == 0) ? StartByte : 8'($urandom_range(0, 255)));
        end
        1: send_frame(rand_chans(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        2: begin
          send_frame(rand_chans(), 8'($urandom_range(0, 255)),
                     EndCodes[3'($urandom_range(0, 4))]);
          send_byte(8'($urandom_range(0, 255)));
        end
        default:
          send_frame(rand_chans(), 8'($urandom_range(0, 255)),
                     EndCodes[3'($urandom_range(0, 4))]);
      endcase
    end
    burst = 1'b0;
    send_byte(StartByte);
    rx_valid_i <= 1'b0;

    while (sb.chans_due_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.chans_due_q.size() != 0)
      sb.mismatch($sformatf("%0d channel items never arrived", sb.chans_due_q.size()));

    $display("Fed %0d bytes; %0d frames decoded, %0d with failsafe or frame lost set.",
             sb.bytes_taken, sb.frames_good, sb.frames_fs);
    $display("Checked %0d channel items, %0d mismatches.", sb.items_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("sbus_frame_receiver verification clean");
    end else begin
      $display("sbus_frame_receiver verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/sbr_pkg.sv
design/sbr_front.sv
design/sbr_queue.sv
design/sbr_back.sv
design/sbus_frame_receiver.sv
test/tb_sbus_frame_receiver.sv
